FILE: src/skf_pkg.sv
package skf_pkg;

    localparam int SAMPLE_WIDTH_DEFAULT = 16;

    localparam int DATA_W      = 32;
    localparam int GAIN_W      = 17;
    localparam int CFG_INDEX_W = 8;

    localparam logic [GAIN_W-1:0] ONE_Q16   = 17'h1_0000;
    localparam logic [DATA_W-1:0] COV_RESET = 32'd655360;
    localparam logic [DATA_W-1:0] Q_RESET   = 32'd655;
    localparam logic [DATA_W-1:0] R_RESET   = 32'd65536;

    localparam logic [CFG_INDEX_W-1:0] REG_PROCESS_NOISE     = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MEASUREMENT_NOISE = 8'd1;

endpackage

FILE: src/skf_divider.sv
module skf_divider (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [skf_pkg::DATA_W-1:0]          dividend,
    input  logic [skf_pkg::DATA_W:0]            divisor,
    output logic                                done,
    output logic [skf_pkg::GAIN_W-1:0]          quotient
);
    import skf_pkg::*;

    // Computes (dividend << 16) / divisor, one quotient bit per cycle.
    // Caller guarantees dividend <= divisor, so the quotient fits GAIN_W bits.
    localparam int CNT_W = $clog2(GAIN_W);
    localparam logic [CNT_W-1:0] CNT_FIRST = CNT_W'(GAIN_W - 1);

    logic [DATA_W:0]   rem_reg,     rem_next;
    logic [DATA_W:0]   divisor_reg, divisor_next;
    logic [GAIN_W-1:0] quot_reg,    quot_next;
    logic [CNT_W-1:0]  cnt_reg,     cnt_next;
    logic              busy_reg,    busy_next;
    logic              done_reg,    done_next;
    logic              low_bit_reg, low_bit_next;

    logic              shift_in;
    logic [DATA_W+1:0] trial;
    logic [DATA_W+1:0] trial_sub;
    logic              trial_ge;

    assign shift_in  = (cnt_reg == CNT_FIRST) ? low_bit_reg : 1'b0;
    assign trial     = {rem_reg, shift_in};
    assign trial_ge  = trial >= {1'b0, divisor_reg};
    assign trial_sub = trial - {1'b0, divisor_reg};

    always_comb
    begin
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        quot_next    = quot_reg;
        cnt_next     = cnt_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        low_bit_next = low_bit_reg;
        if (start)
        begin
            rem_next     = {2'b00, dividend[DATA_W-1:1]};
            low_bit_next = dividend[0];
            divisor_next = divisor;
            quot_next    = '0;
            cnt_next     = CNT_FIRST;
            busy_next    = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = trial_ge ? trial_sub[DATA_W:0] : trial[DATA_W:0];
            quot_next = {quot_reg[GAIN_W-2:0], trial_ge};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        quot_reg    <= quot_next;
        low_bit_reg <= low_bit_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

FILE: src/skf_multiplier.sv
module skf_multiplier #(
    parameter int A_W = 33,
    parameter int B_W = 18
) (
    input  logic                   clk,
    input  logic signed [A_W-1:0]  op_a,
    input  logic signed [B_W-1:0]  op_b,
    output logic signed [A_W+B_W-1:0] product
);
    import skf_pkg::*;

    logic signed [A_W+B_W-1:0] product_reg, product_next;

    assign product_next = (A_W+B_W)'(op_a) * (A_W+B_W)'(op_b);

    always_ff @(posedge clk)
    begin
        product_reg <= product_next;
    end

    assign product = product_reg;

endmodule

FILE: src/scalar_kalman_filter_unit.sv
// One-dimensional Kalman filter with unit transition and observation factors.
// Each accepted measurement (signed integer) updates a signed Q16.16 estimate
// and an unsigned Q16.16 error covariance, and yields one result: the new
// estimate and the Q1.16 gain used (65536 means 1.0). An update first forms the
// saturated prior covariance, then the denominator, then runs the bit-serial
// gain divider (one quotient bit per cycle for 17 bits, then the quotient is
// handed back), and then uses one shared registered multiplier for the
// estimate and covariance updates. The input is stalled for the whole
// update, so a new measurement is taken only after it finishes. A finished
// result sits in an output register, so the next measurement can be taken
// while it waits; an update that completes while the previous result is
// still unread holds in its last state until the output register frees.
// Noise registers may be written only while no transaction is in progress.
module scalar_kalman_filter_unit #(
    parameter int SAMPLE_WIDTH = skf_pkg::SAMPLE_WIDTH_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [skf_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [skf_pkg::DATA_W-1:0]            cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]        measurement,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [skf_pkg::DATA_W-1:0]     filtered_value,
    output logic [skf_pkg::GAIN_W-1:0]            gain
);
    import skf_pkg::*;

    localparam int Z_W = SAMPLE_WIDTH + 16;
    localparam int A_W = ((Z_W > DATA_W) ? Z_W : DATA_W) + 1;
    localparam int B_W = GAIN_W + 1;
    localparam int P_W = A_W + B_W;
    localparam int D_W = P_W - 16;
    localparam int N_W = D_W + 1;

    localparam logic signed [N_W-1:0] EST_MAX = $signed({{(N_W-DATA_W){1'b0}}, 32'h7FFF_FFFF});
    localparam logic signed [N_W-1:0] EST_MIN = $signed({{(N_W-DATA_W){1'b1}}, 32'h8000_0000});

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PRIOR = 3'd1;
    localparam logic [2:0] S_SETUP = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_MUL1  = 3'd4;
    localparam logic [2:0] S_MUL2  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]                     state_reg,      state_next;
    logic [DATA_W-1:0]              q_reg,          q_next;
    logic [DATA_W-1:0]              r_reg,          r_next;
    logic signed [DATA_W-1:0]       est_reg,        est_next;
    logic [DATA_W-1:0]              cov_reg,        cov_next;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg,     sample_next;
    logic [DATA_W-1:0]              prior_reg,      prior_next;
    logic                           den_zero_reg,   den_zero_next;
    logic signed [A_W-1:0]          diff_reg,       diff_next;
    logic [GAIN_W-1:0]              k_reg,          k_next;
    logic signed [DATA_W-1:0]       est_new_reg,    est_new_next;
    logic                           out_valid_reg,  out_valid_next;
    logic signed [DATA_W-1:0]       out_value_reg,  out_value_next;
    logic [GAIN_W-1:0]              out_gain_reg,   out_gain_next;

    logic                           in_accept;
    logic                           out_free;
    logic [DATA_W:0]                cov_sum;
    logic [DATA_W:0]                denom;
    logic signed [A_W-1:0]          z_ext;
    logic signed [A_W-1:0]          est_ext;
    logic                           div_start;
    logic                           div_done;
    logic [GAIN_W-1:0]              div_quot;
    logic signed [A_W-1:0]          mul_a;
    logic signed [B_W-1:0]          mul_b;
    logic signed [P_W-1:0]          prod;
    logic signed [D_W-1:0]          delta;
    logic signed [N_W-1:0]          est_sum;
    logic signed [DATA_W-1:0]       est_sat;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign cov_sum = {1'b0, cov_reg} + {1'b0, q_reg};
    assign denom   = {1'b0, prior_reg} + {1'b0, r_reg};
    assign z_ext   = $signed({{(A_W-Z_W){sample_reg[SAMPLE_WIDTH-1]}}, sample_reg, 16'h0000});
    assign est_ext = $signed({{(A_W-DATA_W){est_reg[DATA_W-1]}}, est_reg});

    assign div_start = (state_reg == S_SETUP);

    skf_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prior_reg),
        .divisor  (denom),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Estimate update uses diff * K; the covariance update uses prior * (1 - K).
    assign mul_a = (state_reg == S_MUL1) ? diff_reg
                                         : $signed({{(A_W-DATA_W){1'b0}}, prior_reg});
    assign mul_b = (state_reg == S_MUL1) ? $signed({1'b0, k_reg})
                                         : $signed({1'b0, ONE_Q16 - k_reg});

    skf_multiplier #(
        .A_W (A_W),
        .B_W (B_W)
    ) u_multiplier (
        .clk     (clk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (prod)
    );

    // Arithmetic shift gives the floor of product / 65536.
    assign delta   = prod[P_W-1:16];
    assign est_sum = $signed({{(N_W-DATA_W){est_reg[DATA_W-1]}}, est_reg})
                   + $signed({delta[D_W-1], delta});

    always_comb
    begin
        priority if (est_sum > EST_MAX)
        begin
            est_sat = 32'sh7FFF_FFFF;
        end
        else if (est_sum < EST_MIN)
        begin
            est_sat = $signed(32'h8000_0000);
        end
        else
        begin
            est_sat = est_sum[DATA_W-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        est_next       = est_reg;
        cov_next       = cov_reg;
        sample_next    = sample_reg;
        prior_next     = prior_reg;
        den_zero_next  = den_zero_reg;
        diff_next      = diff_reg;
        k_next         = k_reg;
        est_new_next   = est_new_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_value_next = out_value_reg;
        out_gain_next  = out_gain_reg;

        if (cfg_we)
        begin
            if (cfg_index == REG_PROCESS_NOISE)
            begin
                q_next = cfg_data;
            end
            else if (cfg_index == REG_MEASUREMENT_NOISE)
            begin
                r_next = cfg_data;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    sample_next = measurement;
                    state_next  = S_PRIOR;
                end
            end
            S_PRIOR:
            begin
                prior_next = cov_sum[DATA_W] ? '1 : cov_sum[DATA_W-1:0];
                state_next = S_SETUP;
            end
            S_SETUP:
            begin
                den_zero_next = (denom == '0);
                diff_next     = z_ext - est_ext;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    k_next     = den_zero_reg ? ONE_Q16 : div_quot;
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                est_new_next = est_sat;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    est_next       = est_new_reg;
                    cov_next       = prod[DATA_W+15:16];
                    out_valid_next = 1'b1;
                    out_value_next = est_new_reg;
                    out_gain_next  = k_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            q_reg         <= Q_RESET;
            r_reg         <= R_RESET;
            est_reg       <= '0;
            cov_reg       <= COV_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            q_reg         <= q_next;
            r_reg         <= r_next;
            est_reg       <= est_next;
            cov_reg       <= cov_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg    <= sample_next;
        prior_reg     <= prior_next;
        den_zero_reg  <= den_zero_next;
        diff_reg      <= diff_next;
        k_reg         <= k_next;
        est_new_reg   <= est_new_next;
        out_value_reg <= out_value_next;
        out_gain_reg  <= out_gain_next;
    end

    assign out_valid      = out_valid_reg;
    assign filtered_value = out_value_reg;
    assign gain           = out_gain_reg;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == S_PRIOR)
        else $error("accepted transaction did not start an update");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide phase");

    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MUL1 |-> k_reg <= ONE_Q16)
        else $error("gain above one");

    a_unit_gain_clears_cov: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && k_reg == ONE_Q16) |-> prod[DATA_W+15:16] == '0)
        else $error("unit gain left nonzero covariance");

    a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("result not delivered on completion");
`endif

endmodule

FILE: tb/tb_scalar_kalman_filter_unit.sv
module tb_scalar_kalman_filter_unit;

    import skf_pkg::*;

    localparam int SW = SAMPLE_WIDTH_DEFAULT;
    localparam longint ONE = 65536;
    localparam longint EST_MAX = 64'sd2147483647;
    localparam longint EST_MIN = -64'sd2147483648;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_FIRST = REG_MEASUREMENT_NOISE + 1'b1;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LAST = '1;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [GAIN_W-1:0]        gain;
    } estimate_t;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]   cfg_index = '0;
    logic [DATA_W-1:0]        cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic signed [SW-1:0]     measurement = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DATA_W-1:0] filtered_value;
    logic [GAIN_W-1:0]        gain;

    scalar_kalman_filter_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .measurement    (measurement),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .filtered_value (filtered_value),
        .gain           (gain)
    );

    // filter state and noise settings as the block should hold them
    logic signed [DATA_W-1:0] estimate = '0;
    logic [DATA_W-1:0]        covariance = COV_RESET;
    logic [DATA_W-1:0]        q_noise = Q_RESET;
    logic [DATA_W-1:0]        r_noise = R_RESET;

    logic signed [SW-1:0] pending_samples[$];
    estimate_t            expected_estimates[$];
    estimate_t            oldest;
    int                   errors = 0;
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("tb: failure");
        $finish;
    end

    function automatic void kalman_update(input logic signed [SW-1:0] sample);
        longint          z;
        longint          k;
        longint          next;
        longint          cov_next;
        longint unsigned prior;
        longint unsigned denom;
        estimate_t       res;
        z = longint'(sample) * ONE;
        prior = longint'(covariance) + longint'(q_noise);
        if (prior > 64'hFFFF_FFFF)
            prior = 64'hFFFF_FFFF;
        denom = prior + longint'(r_noise);
        if (denom == 0)
            k = ONE;
        else
            k = longint'((prior << 16) / denom);
        if (k > ONE)
            k = ONE;
        next = longint'(estimate) + (((z - longint'(estimate)) * k) >>> 16);
        if (next > EST_MAX)
            next = EST_MAX;
        if (next < EST_MIN)
            next = EST_MIN;
        estimate = next[DATA_W-1:0];
        cov_next = ((ONE - k) * longint'(prior)) >> 16;
        covariance = cov_next[DATA_W-1:0];
        res.value = estimate;
        res.gain = k[GAIN_W-1:0];
        expected_estimates.push_back(res);
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
                kalman_update(measurement);
            if (pending_samples.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                measurement <= pending_samples.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_estimates.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected transaction: value %0d gain %0d",
                                 filtered_value, gain);
                    errors++;
                end
                else
                begin
                    oldest = expected_estimates.pop_front();
                    if (filtered_value !== oldest.value || gain !== oldest.gain)
                    begin
                        if (errors < 10)
                            $display("mismatch: value exp %0d got %0d, gain exp %0d got %0d",
                                     oldest.value, filtered_value, oldest.gain, gain);
                        errors++;
                    end
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    task automatic set_mode(input int mode);
        case (mode)
            1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
            3: begin send_idle_pct = 13; recv_stall_pct = 13; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
        endcase
    endtask

    task automatic drain();
        @(negedge clk);
        while (pending_samples.size() != 0 || in_valid || expected_estimates.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == REG_PROCESS_NOISE)
            q_noise = val;
        else if (idx == REG_MEASUREMENT_NOISE)
            r_noise = val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_noise();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2, 3: return $urandom;
            default: return $urandom_range(0, 32'h0010_0000);
        endcase
    endfunction

    function automatic logic signed [SW-1:0] pick_sample(input int level);
        int v;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = $urandom_range(0, 1) ? (1 << (SW - 1)) - 1 : -(1 << (SW - 1));
            default: v = level + int'($urandom_range(0, 64)) - 32;
        endcase
        return v[SW-1:0];
    endfunction

    task automatic push_samples(input int s[]);
        foreach (s[i])
            pending_samples.push_back(s[i][SW-1:0]);
    endtask

    initial
    begin
        int level;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_mode(0);
        push_samples('{0, 32767, 32767, -32768, -32768, -1, 1, 100});
        drain();

        // zero measurement noise, then zero denominator; unused indexes ignored
        write_reg(REG_PROCESS_NOISE, '0);
        write_reg(REG_MEASUREMENT_NOISE, '0);
        write_reg(REG_UNUSED_FIRST, $urandom);
        write_reg(REG_UNUSED_LAST, '1);
        set_mode(3);
        push_samples('{1000, -1000, 32767, -32768});
        drain();

        // saturating prior
        write_reg(REG_PROCESS_NOISE, '1);
        write_reg(REG_MEASUREMENT_NOISE, '1);
        set_mode(1);
        push_samples('{-32768, 32767, 0, -5});
        drain();

        write_reg(REG_MEASUREMENT_NOISE, '0);
        set_mode(2);
        push_samples('{7, -32768, 32767});
        drain();

        write_reg(REG_PROCESS_NOISE, '0);
        write_reg(REG_MEASUREMENT_NOISE, '1);
        set_mode(0);
        push_samples('{32767, -32768, 0});
        drain();

        for (int p = 0; p < 8; p++)
        begin
            write_reg(REG_PROCESS_NOISE, pick_noise());
            write_reg(REG_MEASUREMENT_NOISE, pick_noise());
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_INDEX_W'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
                          $urandom);
            set_mode(p % 4);
            level = int'($urandom_range(0, 64000)) - 32000;
            repeat (50) pending_samples.push_back(pick_sample(level));
            drain();
        end

        repeat (30) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: scalar_kalman_filter_unit.f
src/skf_pkg.sv
src/skf_divider.sv
src/skf_multiplier.sv
src/scalar_kalman_filter_unit.sv
tb/tb_scalar_kalman_filter_unit.sv
